### rtl/wia_pkg.sv
// Shared types and constants for the wide integer ALU.
// No dependencies; imported by wia_step, wide_integer_alu_256_core and the testbench.
package wia_pkg;

  localparam int unsigned WIA_WORDS_DEFAULT = 4;
  localparam int unsigned WIA_IO_WORDS      = 4;
  localparam int unsigned WIA_WORD_W        = 64;
  localparam int unsigned WIA_SHAMT_W       = 8;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_AND  = 4'd3,
    OP_OR   = 4'd4,
    OP_XOR  = 4'd5,
    OP_SHL  = 4'd6,
    OP_SHR  = 4'd7,
    OP_UDIV = 4'd8,
    OP_UMOD = 4'd9,
    OP_SDIV = 4'd10,
    OP_SMOD = 4'd11,
    OP_UCMP = 4'd12,
    OP_SCMP = 4'd13,
    OP_NEG  = 4'd14,
    OP_SABS = 4'd15
  } wia_op_e;

  // What the iteration stages do with a request.
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_QUO  = 2'd2,
    KIND_REM  = 2'd3
  } wia_kind_e;

  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;
  localparam logic [1:0] ORDER_LESS    = 2'b11;

  typedef struct packed {
    logic       valid;
    wia_kind_e  kind;
    logic       neg_res;
    logic       div_zero;
    logic [1:0] order;
  } wia_ctl_t;

endpackage

### rtl/wia_step.sv
// One iteration stage of the ALU pipeline: one restoring divide step or one
// shift-and-add multiply step per request. Depends on wia_pkg.
module wia_step #(
  parameter int unsigned WORDS = wia_pkg::WIA_WORDS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  wia_pkg::wia_ctl_t        ctl_i,
  input  logic [64*WORDS-1:0]      x_i,
  input  logic [64*WORDS-1:0]      d_i,
  input  logic [64*WORDS-1:0]      rem_i,
  input  logic [64*WORDS-1:0]      q_i,
  output wia_pkg::wia_ctl_t        ctl_o,
  output logic [64*WORDS-1:0]      x_o,
  output logic [64*WORDS-1:0]      d_o,
  output logic [64*WORDS-1:0]      rem_o,
  output logic [64*WORDS-1:0]      q_o
);
  import wia_pkg::*;

  localparam int unsigned N = 64 * WORDS;

  wia_ctl_t       ctl_q;
  logic [N-1:0]   x_q, d_q, rem_q, q_q;
  logic [N-1:0]   rem_d, q_d, sh_rem, addend;
  logic [N:0]     diff;

  always_comb begin
    sh_rem = {rem_i[N-2:0], x_i[N-1]};
    diff   = {rem_i[N-1], sh_rem} - {1'b0, d_i};
    addend = x_i[N-1] ? d_i : '0;
    rem_d  = rem_i;
    q_d    = q_i;
    case (ctl_i.kind)
      KIND_MUL: begin
        rem_d = {rem_i[N-2:0], 1'b0} + addend;
      end
      KIND_QUO, KIND_REM: begin
        // A shifted-out top bit means the partial remainder exceeds the divisor.
        if (!diff[N]) begin
          rem_d = diff[N-1:0];
          q_d   = {q_i[N-2:0], 1'b1};
        end else begin
          rem_d = sh_rem;
          q_d   = {q_i[N-2:0], 1'b0};
        end
      end
      default: begin
        rem_d = rem_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= {x_i[N-2:0], 1'b0};
      d_q   <= d_i;
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign d_o   = d_q;
  assign rem_o = rem_q;
  assign q_o   = q_q;

endmodule

### rtl/wide_integer_alu_256.sv
// Top level of the wide integer ALU: input capture, operand preparation,
// the chain of wia_step stages and the result stage. Depends on wia_pkg, wia_step.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | in        | in_valid_i / in_stall_o   | op_i, a_word0..3_i, b_word0..3_i
//  out     | out       | out_valid_o / out_stall_i | result_word0..3_o, order_o
//
// A request passes through one capture stage, one preparation stage, one stage per
// operand bit for the shared multiply/divide chain, and the output register.
// One request is accepted every cycle unless the output is stalled.
// Reset clears the valid bits and control fields, not the data registers. A stalled
// output holding a request freezes the pipeline, so nothing is lost or repeated.
module wide_integer_alu_256_core #(
  parameter int unsigned WORDS = wia_pkg::WIA_WORDS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [3:0]                        op_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    a_word0_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    a_word1_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    a_word2_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    a_word3_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    b_word0_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    b_word1_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    b_word2_i,
  input  logic [wia_pkg::WIA_WORD_W-1:0]    b_word3_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wia_pkg::WIA_WORD_W-1:0]    result_word0_o,
  output logic [wia_pkg::WIA_WORD_W-1:0]    result_word1_o,
  output logic [wia_pkg::WIA_WORD_W-1:0]    result_word2_o,
  output logic [wia_pkg::WIA_WORD_W-1:0]    result_word3_o,
  output logic signed [1:0]                 order_o
);
  import wia_pkg::*;

  localparam int unsigned N = 64 * WORDS;

  // The whole pipeline moves together unless the output holds a request
  // that the consumer is not taking.
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Capture stage: spread the four port words over the internal width.
  logic [WIA_WORD_W-1:0] a_io [WIA_IO_WORDS];
  logic [WIA_WORD_W-1:0] b_io [WIA_IO_WORDS];
  logic [N-1:0]          a_in, b_in;

  assign a_io[0] = a_word0_i;
  assign a_io[1] = a_word1_i;
  assign a_io[2] = a_word2_i;
  assign a_io[3] = a_word3_i;
  assign b_io[0] = b_word0_i;
  assign b_io[1] = b_word1_i;
  assign b_io[2] = b_word2_i;
  assign b_io[3] = b_word3_i;

  always_comb begin
    a_in = '0;
    b_in = '0;
    for (int i = 0; i < WORDS; i++) begin
      if (i < WIA_IO_WORDS) begin
        a_in[i*WIA_WORD_W +: WIA_WORD_W] = a_io[i];
        b_in[i*WIA_WORD_W +: WIA_WORD_W] = b_io[i];
      end
    end
  end

  logic         valid_a_q;
  wia_op_e      op_a_q;
  logic [N-1:0] a_a_q, b_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (adv) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_a_q <= wia_op_e'(op_i);
      a_a_q  <= a_in;
      b_a_q  <= b_in;
    end
  end

  // Preparation stage: operations other than multiply and divide finish here;
  // multiply and divide get their operands loaded into the iteration chain.
  logic                   neg_a, neg_b, b_zero;
  logic [N-1:0]           abs_a, abs_b, simple_r;
  logic [WIA_SHAMT_W-1:0] shamt;
  wia_ctl_t               ctl_b_d;
  logic [N-1:0]           x_b_d, d_b_d;

  always_comb begin
    neg_a  = a_a_q[N-1];
    neg_b  = b_a_q[N-1];
    abs_a  = neg_a ? (~a_a_q + 1'b1) : a_a_q;
    abs_b  = neg_b ? (~b_a_q + 1'b1) : b_a_q;
    b_zero = (b_a_q == '0);
    shamt  = b_a_q[WIA_SHAMT_W-1:0];

    ctl_b_d          = '0;
    ctl_b_d.valid    = valid_a_q;
    ctl_b_d.kind     = KIND_PASS;
    ctl_b_d.order    = ORDER_EQUAL;
    x_b_d            = '0;
    d_b_d            = '0;
    simple_r         = '0;

    case (op_a_q)
      OP_ADD: simple_r = a_a_q + b_a_q;
      OP_SUB: simple_r = a_a_q - b_a_q;
      OP_AND: simple_r = a_a_q & b_a_q;
      OP_OR:  simple_r = a_a_q | b_a_q;
      OP_XOR: simple_r = a_a_q ^ b_a_q;
      OP_SHL: simple_r = a_a_q << shamt;
      OP_SHR: simple_r = a_a_q >> shamt;
      OP_NEG: simple_r = ~a_a_q + 1'b1;
      OP_SABS: simple_r = abs_a;
      OP_MUL: begin
        // The multiplier bits are consumed from x, most significant first.
        ctl_b_d.kind = KIND_MUL;
        x_b_d        = b_a_q;
        d_b_d        = a_a_q;
      end
      OP_UDIV, OP_UMOD: begin
        ctl_b_d.kind     = (op_a_q == OP_UDIV) ? KIND_QUO : KIND_REM;
        ctl_b_d.div_zero = b_zero;
        x_b_d            = a_a_q;
        d_b_d            = b_a_q;
      end
      OP_SDIV, OP_SMOD: begin
        // Divide magnitudes, then fix the sign at the end of the chain.
        ctl_b_d.kind     = (op_a_q == OP_SDIV) ? KIND_QUO : KIND_REM;
        ctl_b_d.div_zero = b_zero;
        ctl_b_d.neg_res  = (op_a_q == OP_SDIV) ? (neg_a ^ neg_b) : neg_a;
        x_b_d            = abs_a;
        d_b_d            = abs_b;
      end
      OP_UCMP: begin
        if (a_a_q < b_a_q) begin
          ctl_b_d.order = ORDER_LESS;
        end else if (a_a_q > b_a_q) begin
          ctl_b_d.order = ORDER_GREATER;
        end
      end
      OP_SCMP: begin
        if ($signed(a_a_q) < $signed(b_a_q)) begin
          ctl_b_d.order = ORDER_LESS;
        end else if ($signed(a_a_q) > $signed(b_a_q)) begin
          ctl_b_d.order = ORDER_GREATER;
        end
      end
      default: simple_r = '0;
    endcase
  end

  // Chain links: entry 0 is the preparation register, entry k the k-th step.
  wia_ctl_t     ctl_s [N+1];
  logic [N-1:0] x_s   [N+1];
  logic [N-1:0] d_s   [N+1];
  logic [N-1:0] rem_s [N+1];
  logic [N-1:0] q_s   [N+1];

  wia_ctl_t     ctl_b_q;
  logic [N-1:0] x_b_q, d_b_q, rem_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (adv) begin
      ctl_b_q <= ctl_b_d;
    end
  end

  // Pass-through results ride in the remainder field, which the steps hold.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_b_q   <= x_b_d;
      d_b_q   <= d_b_d;
      rem_b_q <= simple_r;
    end
  end

  assign ctl_s[0] = ctl_b_q;
  assign x_s[0]   = x_b_q;
  assign d_s[0]   = d_b_q;
  assign rem_s[0] = rem_b_q;
  assign q_s[0]   = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    wia_step #(
      .WORDS (WORDS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_s[k]),
      .x_i    (x_s[k]),
      .d_i    (d_s[k]),
      .rem_i  (rem_s[k]),
      .q_i    (q_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .x_o    (x_s[k+1]),
      .d_o    (d_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .q_o    (q_s[k+1])
    );
  end

  // Result stage: pick quotient or remainder, apply the sign, and clear
  // the result for a zero divisor.
  wia_ctl_t     ctl_f;
  logic [N-1:0] pick, res_d;

  always_comb begin
    ctl_f = ctl_s[N];
    pick  = (ctl_f.kind == KIND_QUO) ? q_s[N] : rem_s[N];
    res_d = ctl_f.neg_res ? (~pick + 1'b1) : pick;
    if (ctl_f.div_zero) begin
      res_d = '0;
    end
  end

  logic [N-1:0] res_q;
  logic [1:0]   order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= res_d;
      order_q <= ctl_f.order;
    end
  end

  // Result words above the internal width read as zero.
  logic [WIA_WORD_W-1:0] res_io [WIA_IO_WORDS];

  always_comb begin
    for (int i = 0; i < WIA_IO_WORDS; i++) begin
      res_io[i] = '0;
      if (i < WORDS) begin
        res_io[i] = res_q[i*WIA_WORD_W +: WIA_WORD_W];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_word0_o = res_io[0];
  assign result_word1_o = res_io[1];
  assign result_word2_o = res_io[2];
  assign result_word3_o = res_io[3];
  assign order_o        = $signed(order_q);

endmodule

### verif/tb_wide_integer_alu_256_core.sv
// Self-checking testbench for wide_integer_alu_256_core at the default width.
// Depends on wia_pkg and the core RTL; a local predictor computes every expected result.
`timescale 1ns / 1ps

module tb_wide_integer_alu_256_core;
  import wia_pkg::*;

  // A request as the driver presents it.
  typedef struct {
    wia_op_e    op;
    logic [255:0] a;
    logic [255:0] b;
  } alu_req_t;

  // The result that a request should produce.
  typedef struct {
    logic [255:0]       value;
    logic signed [1:0]  order;
  } alu_res_t;

  localparam int LATENCY     = 259;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] op_i = '0;
  logic [63:0] a_word0_i = '0, a_word1_i = '0, a_word2_i = '0, a_word3_i = '0;
  logic [63:0] b_word0_i = '0, b_word1_i = '0, b_word2_i = '0, b_word3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] result_word0_o, result_word1_o, result_word2_o, result_word3_o;
  logic signed [1:0] order_o;

  wide_integer_alu_256_core dut (.*);

  // 4 ns clock: two ns high, two ns low.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       cycles = 0;
  int       send_idle_pct = 0;   // chance per cycle that the driver holds back
  int       recv_stall_pct = 0;  // chance per cycle that the monitor stalls
  int       hold_off = 0;        // cycles of forced stall still to run
  bit       draining = 1'b0;     // driver offers nothing while set
  int       op_count[16];

  // Stall as seen at the last rising edge, so the driver knows whether its
  // request was accepted there.
  logic in_stall_q = 1'b0;

  // ---------------------------------------------------------------------
  // Predictor. Division is computed as restoring division on 257 bits so
  // the bit shifted out of the partial remainder is kept.
  // ---------------------------------------------------------------------
  function automatic void udivide(input logic [255:0] n, input logic [255:0] d,
                                  output logic [255:0] quo, output logic [255:0] rem);
    logic [256:0] r;
    quo = '0;
    r   = '0;
    if (d == '0) begin
      rem = '0;
      return;
    end
    for (int i = 255; i >= 0; i--) begin
      r = {r[255:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        quo[i] = 1'b1;
      end
    end
    rem = r[255:0];
  endfunction

  function automatic alu_res_t alu_predict(input alu_req_t rq);
    alu_res_t     res;
    logic [255:0] ua, ub, quo, rem;
    logic         na, nb;
    res.value = '0;
    res.order = 2'sd0;
    na = rq.a[255];
    nb = rq.b[255];
    case (rq.op)
      OP_ADD: res.value = rq.a + rq.b;
      OP_SUB: res.value = rq.a - rq.b;
      OP_MUL: res.value = rq.a * rq.b;
      OP_AND: res.value = rq.a & rq.b;
      OP_OR:  res.value = rq.a | rq.b;
      OP_XOR: res.value = rq.a ^ rq.b;
      // Amounts are 0..255, always below the width, so plain shifts suffice.
      OP_SHL: res.value = rq.a << rq.b[7:0];
      OP_SHR: res.value = rq.a >> rq.b[7:0];
      OP_UDIV, OP_UMOD: begin
        udivide(rq.a, rq.b, quo, rem);
        res.value = (rq.op == OP_UDIV) ? quo : rem;
      end
      OP_SDIV, OP_SMOD: begin
        ua = na ? -rq.a : rq.a;
        ub = nb ? -rq.b : rq.b;
        udivide(ua, ub, quo, rem);
        if (na != nb) quo = -quo;
        if (na) rem = -rem;
        res.value = (rq.op == OP_SDIV) ? quo : rem;
      end
      OP_UCMP, OP_SCMP: begin
        if (rq.op == OP_SCMP && na != nb) res.order = na ? -2'sd1 : 2'sd1;
        else if (rq.a < rq.b) res.order = -2'sd1;
        else if (rq.a > rq.b) res.order = 2'sd1;
      end
      OP_NEG: res.value = -rq.a;
      default: res.value = na ? -rq.a : rq.a;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Operands with a bias toward edge values and short magnitudes, so that
  // compares see equality and divisions see small and zero divisors.
  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    v = {rand_word(), rand_word(), rand_word(), rand_word()};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = {1'b1, 255'b0};
      3: v = {1'b0, {255{1'b1}}};
      4: v = v >> $urandom_range(0, 255);
      5: v = -(v >> $urandom_range(128, 255));
      6: v = 256'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_req(input wia_op_e op, input logic [255:0] a, input logic [255:0] b);
    alu_req_t rq;
    rq.op = op;
    rq.a  = a;
    rq.b  = b;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_all_sent();
    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    logic [255:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_operand();
      b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
      queue_req(wia_op_e'($urandom_range(0, 15)), a, b);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the head of pending_reqs, changing inputs only at the
  // falling edge. A request held under stall keeps its payload.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_q) begin
        // Previous request was taken at the last rising edge.
      end
      if (!in_valid_i || !in_stall_q) begin
        if (!draining && pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          alu_req_t rq;
          rq = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          op_i       <= rq.op;
          {a_word3_i, a_word2_i, a_word1_i, a_word0_i} <= rq.a;
          {b_word3_i, b_word2_i, b_word1_i, b_word0_i} <= rq.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The predictor runs on accepted requests at the rising edge.
  always @(posedge clk_i) begin
    in_stall_q <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      alu_req_t rq;
      rq.op = wia_op_e'(op_i);
      rq.a  = {a_word3_i, a_word2_i, a_word1_i, a_word0_i};
      rq.b  = {b_word3_i, b_word2_i, b_word1_i, b_word0_i};
      expected_results.push_back(alu_predict(rq));
      op_count[op_i]++;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation,
  // and drives the output stall at the falling edge.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0d] mismatch: %s", cycles, what);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      alu_res_t want;
      logic [255:0] got;
      got = {result_word3_o, result_word2_o, result_word1_o, result_word0_o};
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (got !== want.value)
          report_mismatch($sformatf("value got %h want %h", got, want.value));
        if (order_o !== want.order)
          report_mismatch($sformatf("order got %0d want %0d", order_o, want.order));
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  localparam logic [255:0] MOST_NEG = {1'b1, 255'b0};
  localparam logic [255:0] MOST_POS = {1'b0, {255{1'b1}}};
  localparam logic [255:0] ALL_ONES = '1;

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes, every operation, and the named corner cases.
    queue_req(OP_ADD, ALL_ONES, 256'd1);
    queue_req(OP_SUB, '0, 256'd1);
    queue_req(OP_MUL, ALL_ONES, ALL_ONES);
    queue_req(OP_AND, ALL_ONES, MOST_NEG);
    queue_req(OP_OR, MOST_POS, MOST_NEG);
    queue_req(OP_XOR, ALL_ONES, MOST_POS);
    queue_req(OP_SHL, ALL_ONES, 256'd255);
    queue_req(OP_SHL, ALL_ONES, {ALL_ONES[255:8], 8'd0});
    queue_req(OP_SHR, ALL_ONES, 256'd64);
    queue_req(OP_SHR, MOST_NEG, 256'd255);
    queue_req(OP_UDIV, ALL_ONES, 256'd3);
    queue_req(OP_UDIV, ALL_ONES, '0);
    queue_req(OP_UMOD, ALL_ONES, MOST_NEG);
    queue_req(OP_UMOD, 256'd5, '0);
    queue_req(OP_SDIV, MOST_NEG, ALL_ONES);
    queue_req(OP_SDIV, -256'sd7, 256'd2);
    queue_req(OP_SDIV, MOST_POS, '0);
    queue_req(OP_SMOD, -256'sd7, 256'd2);
    queue_req(OP_SMOD, 256'd7, -256'sd2);
    queue_req(OP_SMOD, MOST_NEG, '0);
    queue_req(OP_UCMP, ALL_ONES, '0);
    queue_req(OP_UCMP, MOST_POS, MOST_POS);
    queue_req(OP_SCMP, MOST_NEG, MOST_POS);
    queue_req(OP_NEG, MOST_NEG, '0);
    queue_req(OP_SABS, MOST_NEG, ALL_ONES);
    wait_all_sent();

    // Phase: no idling on either side.
    queue_random(100);
    wait_all_sent();

    // Phase: sender idle most of the time.
    send_idle_pct = 64;
    queue_random(100);
    wait_all_sent();

    // Sender pauses until every expected result has come back.
    draining = 1'b1;
    while (expected_results.size() != 0) @(posedge clk_i);
    draining = 1'b0;

    // Phase: receiver stalls most of the time, with one long hold-off at the
    // start. More requests are queued than the pipeline holds, so the sender
    // is still offering when the pipeline fills and the input is stalled.
    send_idle_pct = 0;
    recv_stall_pct = 64;
    hold_off = 600;
    queue_random(300);
    wait_all_sent();

    // Phase: both sides idle a fifth of the time.
    send_idle_pct = 20;
    recv_stall_pct = 20;
    queue_random(100);
    wait_all_sent();

    // Phase: no idling again to end.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(80);
    wait_all_sent();

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Checked %0d results over 16 opcodes (udiv %0d, sdiv %0d, mul %0d),",
             results_seen, op_count[OP_UDIV], op_count[OP_SDIV], op_count[OP_MUL]);
    $display("with idle and stall phases and a full-pipeline hold-off; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/wia_pkg.sv
rtl/wia_step.sv
rtl/wide_integer_alu_256.sv
verif/tb_wide_integer_alu_256_core.sv
